/* sv/byte_playfair_cipher_macros.svh */
// assertion macros for the byte playfair cipher
// used by the top level only, needs clk and rst_n in scope
`ifndef BYTE_PLAYFAIR_CIPHER_MACROS_SVH
`define BYTE_PLAYFAIR_CIPHER_MACROS_SVH

// same-cycle implication
`define BPF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BPF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/bpf_pkg.sv */
// shared types and constants for the byte playfair cipher
// no dependencies
package bpf_pkg;

  localparam int BYTE_W  = 8;
  localparam int POS_W   = 8;
  localparam int COORD_W = 4;
  localparam int FILL_W  = POS_W + 1;

  localparam logic [BYTE_W-1:0] NULL_BYTE = 8'h00;
  localparam logic [BYTE_W-1:0] PAD_BYTE  = 8'h03;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_KEY    = 2'd1,
    KIND_FINISH = 2'd2,
    KIND_DATA   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_READY = 2'd1,
    STAT_ODD       = 2'd2
  } status_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;
    logic              message_end;
    status_t           status;
  } out_item_t;

  // control into the shared coordinate unit
  typedef struct packed {
    logic [POS_W-1:0] pos_a;
    logic [POS_W-1:0] pos_b;
    logic             decipher;
    logic             take_b;
  } pair_ctl_t;

endpackage

/* sv/bpf_ram.sv */
// single write port, single registered read port ram
// no dependencies
module bpf_ram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/bpf_pair_unit.sv */
// shared row/column unit: square address of one output byte of a pair
// depends on bpf_pkg
module bpf_pair_unit
  import bpf_pkg::*;
(
  input  pair_ctl_t        ctl,
  output logic [POS_W-1:0] addr
);

  logic [COORD_W-1:0] ra, ca, rb, cb;
  logic [COORD_W-1:0] r_self, c_self, c_other, step;

  always_comb begin
    ra      = ctl.pos_a[POS_W-1:COORD_W];
    ca      = ctl.pos_a[COORD_W-1:0];
    rb      = ctl.pos_b[POS_W-1:COORD_W];
    cb      = ctl.pos_b[COORD_W-1:0];
    r_self  = ctl.take_b ? rb : ra;
    c_self  = ctl.take_b ? cb : ca;
    c_other = ctl.take_b ? ca : cb;
    // decipher moves back by one, i.e. adds all ones mod 16
    step    = ctl.decipher ? {COORD_W{1'b1}} : COORD_W'(1);
    if (ra == rb) begin
      addr = {r_self, COORD_W'(c_self + step)};
    end else if (ca == cb) begin
      addr = {COORD_W'(r_self + step), c_self};
    end else begin
      addr = {r_self, c_other};
    end
  end

endmodule

/* sv/byte_playfair_cipher.sv */
// byte playfair cipher top level: sequencer, key store, output stage
// depends on bpf_pkg, bpf_ram, bpf_pair_unit and the assertion macros
//
// Usage: in_data carries kind, in_byte and in_last over valid/ready; results
// leave on out_data over valid/ready; cfg_we/cfg_wdata set the direction
// (0 encipher, 1 decipher); the user must write them only while the block is
// idle, which the block itself does not enforce. Clear key and key byte
// transactions keep in_ready high. Finish square walks all 256 byte values,
// one per cycle, so in_ready is low while it walks. A first data byte of a
// pair is held, and in_ready stays high. The byte that closes a pair needs
// two position reads and two square reads, captured in PA, PB, SX and SY and
// serialized on the single read port of each ram; then FIN loads the output
// stage. The next transaction is taken only after FIN has loaded the results.
// Errors (data before finish, odd decipher input) go from idle straight to FIN.
// The output stage holds up to two results, so a new transaction is taken
// while results still wait; a stalled receiver stops the sequencer only when
// the next results need the output stage.
// Reset clears the used marks, fill count, ready flag, held byte and the
// output stage; the square and position rams are written by the key setup.
`include "byte_playfair_cipher_macros.svh"

module byte_playfair_cipher
  import bpf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_FILL = 7'b0000010,
    ST_PA   = 7'b0000100,
    ST_PB   = 7'b0001000,
    ST_SX   = 7'b0010000,
    ST_SY   = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic                dir_r;
  logic [POS_W-1:0]    fill_i_r, fill_i_nxt;
  logic [FILL_W-1:0]   fill_cnt_r, fill_cnt_nxt;
  logic [255:0]        used_r, used_nxt;
  logic                ready_r, ready_nxt;
  logic                holding_r, holding_nxt;
  logic [BYTE_W-1:0]   held_r, held_nxt;
  logic [BYTE_W-1:0]   b_r, b_nxt;
  logic                last_r, last_nxt;
  logic [POS_W-1:0]    pa_r, pa_nxt, pb_r, pb_nxt;
  logic [BYTE_W-1:0]   x_r, x_nxt;
  out_item_t           res0_r, res0_nxt, res1_r, res1_nxt;
  logic                two_r, two_nxt;

  out_item_t           out_r, pend_data_r;
  logic                out_valid_r, pend_r;
  logic                out_free;

  logic                put;
  logic [BYTE_W-1:0]   put_val;
  logic                sq_we, pos_we;
  logic [POS_W-1:0]    pos_raddr, sq_raddr;
  logic [POS_W-1:0]    pos_rdata;
  logic [BYTE_W-1:0]   sq_rdata, y_fix;
  pair_ctl_t           unit_ctl;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r && !pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= 1'b0;
    end else if (cfg_we) begin
      dir_r <= cfg_wdata;
    end
  end

  // key store: square[pos] = byte, position_of[byte] = pos
  bpf_ram #(.ADDR_W(POS_W), .DATA_W(BYTE_W)) u_square (
    .clk   (clk),
    .we    (sq_we),
    .waddr (fill_cnt_r[POS_W-1:0]),
    .wdata (put_val),
    .raddr (sq_raddr),
    .rdata (sq_rdata)
  );

  bpf_ram #(.ADDR_W(BYTE_W), .DATA_W(POS_W)) u_position (
    .clk   (clk),
    .we    (pos_we),
    .waddr (put_val),
    .wdata (fill_cnt_r[POS_W-1:0]),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  // one coordinate unit, used for the first byte in PB and the second in SX
  assign unit_ctl = '{pa_r, ((state_r == ST_PB) ? pos_rdata : pb_r), dir_r,
                      (state_r == ST_SX)};

  bpf_pair_unit u_unit (
    .ctl  (unit_ctl),
    .addr (sq_raddr)
  );

  assign pos_raddr = (state_r == ST_PA) ? b_r :
                     (holding_r ? held_r : in_data.in_byte);
  assign y_fix     = (dir_r && sq_rdata == NULL_BYTE) ? x_r : sq_rdata;

  always_comb begin
    state_nxt    = state_r;
    fill_i_nxt   = fill_i_r;
    fill_cnt_nxt = fill_cnt_r;
    used_nxt     = used_r;
    ready_nxt    = ready_r;
    holding_nxt  = holding_r;
    held_nxt     = held_r;
    b_nxt        = b_r;
    last_nxt     = last_r;
    pa_nxt       = pa_r;
    pb_nxt       = pb_r;
    x_nxt        = x_r;
    res0_nxt     = res0_r;
    res1_nxt     = res1_r;
    two_nxt      = two_r;
    put          = 1'b0;
    put_val      = in_data.in_byte;
    sq_we        = 1'b0;
    pos_we       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_data.kind)
            KIND_CLEAR: begin
              used_nxt     = '0;
              fill_cnt_nxt = '0;
              ready_nxt    = 1'b0;
              holding_nxt  = 1'b0;
            end
            KIND_KEY: begin
              put = !ready_r;
            end
            KIND_FINISH: begin
              if (!ready_r) begin
                fill_i_nxt = '0;
                state_nxt  = ST_FILL;
              end
            end
            KIND_DATA: begin
              if (!ready_r) begin
                res0_nxt  = '{NULL_BYTE, 1'b1, in_data.in_last, STAT_NOT_READY};
                two_nxt   = 1'b0;
                state_nxt = ST_FIN;
              end else if (!holding_r) begin
                if (!in_data.in_last) begin
                  held_nxt    = in_data.in_byte;
                  holding_nxt = 1'b1;
                end else if (!dir_r) begin
                  // odd final byte, pad it
                  b_nxt     = PAD_BYTE;
                  last_nxt  = 1'b1;
                  state_nxt = ST_PA;
                end else begin
                  res0_nxt  = '{NULL_BYTE, 1'b1, 1'b1, STAT_ODD};
                  two_nxt   = 1'b0;
                  state_nxt = ST_FIN;
                end
              end else begin
                holding_nxt = 1'b0;
                b_nxt       = (!dir_r && held_r == in_data.in_byte) ? NULL_BYTE
                                                                    : in_data.in_byte;
                last_nxt    = in_data.in_last;
                state_nxt   = ST_PA;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        put     = 1'b1;
        put_val = fill_i_r;
        if (fill_i_r == {POS_W{1'b1}}) begin
          ready_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          fill_i_nxt = fill_i_r + POS_W'(1);
        end
      end
      ST_PA: begin
        pa_nxt    = pos_rdata;
        state_nxt = ST_PB;
      end
      ST_PB: begin
        pb_nxt    = pos_rdata;
        state_nxt = ST_SX;
      end
      ST_SX: begin
        x_nxt     = sq_rdata;
        state_nxt = ST_SY;
      end
      ST_SY: begin
        res0_nxt = '{x_r, 1'b0, 1'b0, STAT_OK};
        res1_nxt = '{y_fix, 1'b1, last_r, STAT_OK};
        two_nxt  = 1'b1;
        // stripped pad on the final decipher pair
        if (dir_r && last_r && y_fix == PAD_BYTE) begin
          res0_nxt = '{x_r, 1'b1, 1'b1, STAT_OK};
          two_nxt  = 1'b0;
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (put && !fill_cnt_r[FILL_W-1] && !used_r[put_val]) begin
      sq_we             = 1'b1;
      pos_we            = 1'b1;
      used_nxt[put_val] = 1'b1;
      fill_cnt_nxt      = fill_cnt_r + FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      fill_cnt_r <= '0;
      used_r     <= '0;
      ready_r    <= 1'b0;
      holding_r  <= 1'b0;
      held_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      fill_cnt_r <= fill_cnt_nxt;
      used_r     <= used_nxt;
      ready_r    <= ready_nxt;
      holding_r  <= holding_nxt;
      held_r     <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fill_i_r <= fill_i_nxt;
    b_r      <= b_nxt;
    last_r   <= last_nxt;
    pa_r     <= pa_nxt;
    pb_r     <= pb_nxt;
    x_r      <= x_nxt;
    res0_r   <= res0_nxt;
    res1_r   <= res1_nxt;
    two_r    <= two_nxt;
  end

  // two-deep output stage: out_r is shown, pend_data_r follows it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        if (pend_r) begin
          out_r  <= pend_data_r;
          pend_r <= 1'b0;
        end else begin
          out_valid_r <= 1'b0;
        end
      end
      if (state_r == ST_FIN && out_free) begin
        out_r       <= res0_r;
        out_valid_r <= 1'b1;
        pend_data_r <= res1_r;
        pend_r      <= two_r;
      end
    end
  end

  `BPF_ASSERT_IMP(a_pend_behind_out, pend_r, out_valid_r, "pending result without a shown one")
  `BPF_ASSERT_IMP(a_ready_full, ready_r, fill_cnt_r == FILL_W'(256), "square ready but not full")
  `BPF_ASSERT_IMP(a_fill_not_ready, state_r == ST_FILL, !ready_r, "square fill while ready")
  `BPF_ASSERT_NXT(a_fin_loads, state_r == ST_FIN && out_free, out_valid_r, "results not loaded")

endmodule
